FILE: rtl/skt_pkg.sv
// shared types and constants of the sorted key table
`timescale 1ns / 1ps
package skt_pkg;

	localparam int DEPTH_DEF = 64;

	// request codes
	typedef enum logic [2:0] {
		REQ_INSERT     = 3'd0,
		REQ_LOOKUP     = 3'd1,
		REQ_REMOVE_KEY = 3'd2,
		REQ_REMOVE_AT  = 3'd3,
		REQ_READ_AT    = 3'd4,
		REQ_CLEAR      = 3'd5
	} req_t;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_BAD       = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SRCH,
		S_CMP,
		S_RD_AT,
		S_AT_DATA,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_PUT,
		S_DONE
	} state_t;

endpackage

FILE: rtl/skt_mem.sv
// entry memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module skt_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [63:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [63:0]   rdata
);
	logic [63:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered data
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/skt_ctrl.sv
// request sequencer: binary search, entry shifts and result register
`timescale 1ns / 1ps
module skt_ctrl #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int CW    = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  logic [2:0]    req_type,
	input  logic [31:0]   key,
	input  logic [31:0]   handle,
	input  logic [5:0]    index,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output logic [2:0]    status,
	output logic [31:0]   found_key,
	output logic [31:0]   found_handle,
	output logic [6:0]    entry_count,
	output logic          mem_we,
	output logic [AW-1:0] mem_waddr,
	output logic [63:0]   mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [63:0]   mem_rdata
);
	import skt_pkg::*;

	localparam int IW = (CW > 6) ? CW : 6;

	state_t        state_q, state_d;
	req_t          op_q;
	logic [31:0]   key_q, handle_q;
	logic [5:0]    idx_q;
	logic [CW-1:0] cnt_q, lo_q, hi_q, ptr_q;
	logic [AW-1:0] mid_q;
	status_t       res_status_q;
	logic [31:0]   res_key_q, res_handle_q;
	logic          rsp_valid_q;
	logic [2:0]    rsp_status_q;
	logic [31:0]   rsp_key_q, rsp_handle_q;
	logic [6:0]    rsp_count_q;

	logic [CW:0]   sum_c;
	logic [AW-1:0] mid_c;
	logic          accept, rd_hit, rd_above, out_free, search_left, idx_bad;
	logic          arg_bad, ptr_last_rm, ptr_last_ins;
	req_t          req_c;

	assign accept       = req_valid && !req_stall;
	assign req_stall    = (state_q != S_IDLE);
	assign req_c        = req_t'(req_type);
	assign sum_c        = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c        = AW'(sum_c >> 1);
	assign search_left  = (lo_q < hi_q);
	assign rd_hit       = (mem_rdata[63:32] == key_q);
	assign rd_above     = (key_q > mem_rdata[63:32]);
	assign out_free     = !rsp_valid_q || !rsp_stall;
	assign idx_bad      = (IW'(index) >= IW'(cnt_q));
	assign ptr_last_rm  = ((ptr_q + CW'(1)) >= cnt_q);
	assign ptr_last_ins = ((ptr_q - CW'(1)) == lo_q);

	// argument check at accept time
	always_comb begin
		case (req_c)
			REQ_INSERT:                  arg_bad = (key == 32'd0) || (handle == 32'd0);
			REQ_LOOKUP, REQ_REMOVE_KEY:  arg_bad = (key == 32'd0);
			REQ_REMOVE_AT, REQ_READ_AT:  arg_bad = idx_bad;
			REQ_CLEAR:                   arg_bad = 1'b0;
			default:                     arg_bad = 1'b1;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (arg_bad || req_c == REQ_CLEAR) begin
						state_d = S_DONE;
					end else if (req_c == REQ_REMOVE_AT || req_c == REQ_READ_AT) begin
						state_d = S_RD_AT;
					end else begin
						state_d = S_SRCH;
					end
				end
			end
			S_SRCH: begin
				if (search_left) begin
					state_d = S_CMP;
				end else if (op_q == REQ_INSERT && IW'(cnt_q) < IW'(DEPTH)) begin
					state_d = (cnt_q == lo_q) ? S_PUT : S_SHIFT_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_CMP: begin
				if (!rd_hit) begin
					state_d = S_SRCH;
				end else if (op_q == REQ_REMOVE_KEY) begin
					state_d = ((CW'(mid_q) + CW'(1)) >= cnt_q) ? S_DONE : S_SHIFT_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_RD_AT:   state_d = S_AT_DATA;
			S_AT_DATA: begin
				if (op_q == REQ_REMOVE_AT && (CW'(idx_q) + CW'(1)) < cnt_q) begin
					state_d = S_SHIFT_RD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_SHIFT_RD: state_d = S_SHIFT_WR;
			S_SHIFT_WR: begin
				if (op_q == REQ_INSERT) begin
					state_d = ptr_last_ins ? S_PUT : S_SHIFT_RD;
				end else begin
					state_d = ptr_last_rm ? S_DONE : S_SHIFT_RD;
				end
			end
			S_PUT:  state_d = S_DONE;
			S_DONE: state_d = out_free ? S_IDLE : S_DONE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = AW'(ptr_q);
		mem_wdata = mem_rdata;
		mem_raddr = mid_c;
		unique case (state_q)
			S_RD_AT:    mem_raddr = AW'(idx_q);
			S_SHIFT_RD: mem_raddr = (op_q == REQ_INSERT) ? AW'(ptr_q - CW'(1)) : AW'(ptr_q);
			S_SHIFT_WR: begin
				mem_we    = 1'b1;
				mem_waddr = (op_q == REQ_INSERT) ? AW'(ptr_q) : AW'(ptr_q - CW'(1));
			end
			S_PUT: begin
				mem_we    = 1'b1;
				mem_wdata = {key_q, handle_q};
			end
			default: ;
		endcase
	end

	// request payload and working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req_c;
			key_q    <= key;
			handle_q <= handle;
			idx_q    <= index;
			lo_q     <= '0;
			hi_q     <= cnt_q;
		end
		if (state_q == S_SRCH) begin
			mid_q <= mid_c;
		end
		if (state_q == S_CMP && !rd_hit) begin
			if (rd_above) lo_q <= CW'(mid_q) + CW'(1);
			else          hi_q <= CW'(mid_q);
		end
		// shift pointer setup and stepping
		if (state_q == S_SRCH) begin
			ptr_q <= cnt_q;
		end else if (state_q == S_CMP) begin
			ptr_q <= CW'(mid_q) + CW'(1);
		end else if (state_q == S_AT_DATA) begin
			ptr_q <= CW'(idx_q) + CW'(1);
		end else if (state_q == S_SHIFT_WR) begin
			ptr_q <= (op_q == REQ_INSERT) ? ptr_q - CW'(1) : ptr_q + CW'(1);
		end
	end

	// result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			res_key_q    <= '0;
			res_handle_q <= '0;
			res_status_q <= arg_bad ? ST_BAD : ST_OK;
		end
		if (state_q == S_SRCH && !search_left) begin
			if (op_q != REQ_INSERT)                res_status_q <= ST_NOT_FOUND;
			else if (IW'(cnt_q) >= IW'(DEPTH))     res_status_q <= ST_FULL;
		end
		if (state_q == S_CMP && rd_hit) begin
			if (op_q == REQ_INSERT) begin
				res_status_q <= ST_DUPLICATE;
			end else begin
				res_key_q    <= mem_rdata[63:32];
				res_handle_q <= mem_rdata[31:0];
			end
		end
		if (state_q == S_AT_DATA) begin
			res_key_q    <= mem_rdata[63:32];
			res_handle_q <= mem_rdata[31:0];
		end
	end

	// control state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && req_c == REQ_CLEAR) begin
				cnt_q <= '0;
			end else if (state_q == S_PUT) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (state_q == S_CMP && rd_hit && op_q == REQ_REMOVE_KEY
					&& state_d == S_DONE) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (state_q == S_AT_DATA && op_q == REQ_REMOVE_AT
					&& state_d == S_DONE) begin
				cnt_q <= cnt_q - CW'(1);
			end else if (state_q == S_SHIFT_WR && op_q != REQ_INSERT && ptr_last_rm) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			rsp_status_q <= res_status_q;
			rsp_key_q    <= res_key_q;
			rsp_handle_q <= res_handle_q;
			rsp_count_q  <= 7'(cnt_q);
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = rsp_status_q;
	assign found_key    = rsp_key_q;
	assign found_handle = rsp_handle_q;
	assign entry_count  = rsp_count_q;

endmodule

FILE: rtl/sorted_key_table_core.sv
// top level of the sorted key table
//
//  channel | valid     | stall     | payload
//  request | req_valid | req_stall | req_type, key, handle, index
//  result  | rsp_valid | rsp_stall | status, found_key, found_handle, entry_count
//
// a request steps through setup, one binary search probe (S_SRCH, S_CMP) per halving,
// a read and a write (S_SHIFT_RD, S_SHIFT_WR) per entry shifted, the final insert
// write (S_PUT) and the result hand-off (S_DONE), through the single read and write port of the entry memory
// reset empties the table at once; entries are not cleared
// a new request is taken while the last result waits under rsp_stall
`timescale 1ns / 1ps
module sorted_key_table_core #(
	parameter int DEPTH = skt_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [31:0] key,
	input  logic [31:0] handle,
	input  logic [5:0]  index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [2:0]  status,
	output logic [31:0] found_key,
	output logic [31:0] found_handle,
	output logic [6:0]  entry_count
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [63:0]   mem_wdata, mem_rdata;

	// sequencer
	skt_ctrl #(.DEPTH(DEPTH), .AW(AW), .CW(CW)) u_ctrl (
		.clk, .arst_n, .req_valid, .req_stall, .req_type, .key, .handle, .index,
		.rsp_valid, .rsp_stall, .status, .found_key, .found_handle, .entry_count,
		.mem_we, .mem_waddr, .mem_wdata, .mem_raddr, .mem_rdata
	);

	// entry storage
	skt_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
		.clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
		.raddr(mem_raddr), .rdata(mem_rdata)
	);

endmodule

FILE: rtl/skt_checker.sv
// port level checks of the sorted key table
`timescale 1ns / 1ps
module skt_checker #(
	parameter int DEPTH = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [2:0]  status,
	input logic [31:0] found_key,
	input logic [31:0] found_handle,
	input logic [6:0]  entry_count
);
	import skt_pkg::*;

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(found_key))
		else $error("stalled result changed");

	// failing results carry no entry
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> found_key == 32'd0 && found_handle == 32'd0)
		else $error("failing result carries an entry");

	// full only when count is at capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> {25'd0, entry_count} == 32'(DEPTH))
		else $error("full reported below capacity");

	// a returned entry always has a handle
	a_handle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && found_key != 32'd0 |-> found_handle != 32'd0)
		else $error("entry returned with null handle");

endmodule

bind sorted_key_table_core skt_checker #(.DEPTH(DEPTH)) u_skt_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
	.status(status), .found_key(found_key), .found_handle(found_handle),
	.entry_count(entry_count)
);

FILE: bench/sorted_key_table_core_tb.sv
// testbench of the sorted key table: random and directed requests checked against a table model
`timescale 1ns / 1ps
module sorted_key_table_core_tb;
	import skt_pkg::*;

	localparam int TBL_DEPTH = 64;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] key;
		logic [31:0] handle;
		logic [5:0]  index;
		logic        hold;
	} request_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] found_key;
		logic [31:0] found_handle;
		logic [6:0]  entry_count;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [2:0]  req_type;
	logic [31:0] key;
	logic [31:0] handle;
	logic [5:0]  index;
	logic        rsp_valid;
	logic        rsp_stall;
	logic [2:0]  status;
	logic [31:0] found_key;
	logic [31:0] found_handle;
	logic [6:0]  entry_count;

	request_t pending_reqs[$];
	answer_t  expected_answers[$];
	int       mismatches;
	bit       stimulus_done;
	bit       calm_phase;

	// model of the table contents
	logic [31:0] model_keys[TBL_DEPTH];
	logic [31:0] model_handles[TBL_DEPTH];
	int          model_count;
	// keys known to be in the table, used to aim requests at hits
	logic [31:0] live_keys[$];

	sorted_key_table_core dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .key(key), .handle(handle), .index(index),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.status(status), .found_key(found_key), .found_handle(found_handle),
		.entry_count(entry_count)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int search_pos(logic [31:0] k);
		int lo;
		int hi;
		int mid;
		lo = 0;
		hi = model_count - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			if (model_keys[mid] == k)
				return mid;
			if (k > model_keys[mid])
				lo = mid + 1;
			else
				hi = mid - 1;
		end
		return -1;
	endfunction

	function automatic void drop_entry(int pos);
		for (int i = pos; i + 1 < model_count; i++) begin
			model_keys[i] = model_keys[i + 1];
			model_handles[i] = model_handles[i + 1];
		end
		model_count--;
	endfunction

	// apply one request to the model and queue its answer
	function automatic void predict_answer(request_t r);
		answer_t a;
		int pos;
		int i;
		a = '0;
		a.status = ST_BAD;
		case (r.req_type)
			REQ_INSERT: begin
				if (r.key == 0 || r.handle == 0)
					a.status = ST_BAD;
				else if (search_pos(r.key) >= 0)
					a.status = ST_DUPLICATE;
				else if (model_count >= TBL_DEPTH)
					a.status = ST_FULL;
				else begin
					i = model_count;
					while (i > 0 && model_keys[i - 1] > r.key) begin
						model_keys[i] = model_keys[i - 1];
						model_handles[i] = model_handles[i - 1];
						i--;
					end
					model_keys[i] = r.key;
					model_handles[i] = r.handle;
					model_count++;
					a.status = ST_OK;
				end
			end
			REQ_LOOKUP, REQ_REMOVE_KEY: begin
				if (r.key == 0)
					a.status = ST_BAD;
				else begin
					pos = search_pos(r.key);
					if (pos < 0)
						a.status = ST_NOT_FOUND;
					else begin
						a.found_key = model_keys[pos];
						a.found_handle = model_handles[pos];
						if (r.req_type == REQ_REMOVE_KEY)
							drop_entry(pos);
						a.status = ST_OK;
					end
				end
			end
			REQ_REMOVE_AT, REQ_READ_AT: begin
				if (r.index >= model_count)
					a.status = ST_BAD;
				else begin
					a.found_key = model_keys[r.index];
					a.found_handle = model_handles[r.index];
					if (r.req_type == REQ_REMOVE_AT)
						drop_entry(r.index);
					a.status = ST_OK;
				end
			end
			REQ_CLEAR: begin
				model_count = 0;
				a.status = ST_OK;
			end
			default: a.status = ST_BAD;
		endcase
		a.entry_count = model_count[6:0];
		expected_answers.push_back(a);
	endfunction

	// stimulus-side shadow of keys, to aim lookups and removes
	function automatic void track_keys(request_t r);
		int n;
		case (r.req_type)
			REQ_INSERT:
				if (r.key != 0 && r.handle != 0 && live_keys.size() < TBL_DEPTH) begin
					n = 0;
					foreach (live_keys[j])
						if (live_keys[j] == r.key)
							n = 1;
					if (n == 0)
						live_keys.push_back(r.key);
				end
			REQ_REMOVE_KEY:
				foreach (live_keys[j])
					if (live_keys[j] == r.key) begin
						live_keys.delete(j);
						break;
					end
			REQ_CLEAR: live_keys.delete();
			default: ;
		endcase
	endfunction

	function automatic void queue_req(logic [2:0] t, logic [31:0] k, logic [31:0] h,
		logic [5:0] ix, bit hold);
		request_t r;
		r.req_type = t;
		r.key = k;
		r.handle = h;
		r.index = ix;
		r.hold = hold;
		track_keys(r);
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [31:0] rand_key();
		case ($urandom_range(0, 3))
			0: return $urandom_range(1, 40);
			1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
			default: return $urandom() | 32'd1;
		endcase
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch on %s: got %0h expected %0h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// request driver
	int req_idle;
	bit waiting_drain;
	always @(posedge clk or negedge arst_n) begin
		request_t r;
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_type <= '0;
			key <= '0;
			handle <= '0;
			index <= '0;
			req_idle = 0;
			waiting_drain = 0;
		end else begin
			if (req_valid && !req_stall) begin
				r.req_type = req_type;
				r.key = key;
				r.handle = handle;
				r.index = index;
				predict_answer(r);
			end
			if (!(req_valid && req_stall)) begin
				if (req_idle > 0) begin
					req_idle--;
					req_valid <= 1'b0;
				end else if (waiting_drain) begin
					req_valid <= 1'b0;
					if (expected_answers.size() == 0)
						waiting_drain = 0;
				end else if (pending_reqs.size() > 0 && pending_reqs[0].hold
					&& !(req_valid && !req_stall) && expected_answers.size() != 0) begin
					req_valid <= 1'b0;
					waiting_drain = 1;
				end else if (pending_reqs.size() > 0 && pending_reqs[0].hold
					&& req_valid) begin
					req_valid <= 1'b0;
					waiting_drain = 1;
				end else if (pending_reqs.size() > 0) begin
					r = pending_reqs.pop_front();
					req_valid <= 1'b1;
					req_type <= r.req_type;
					key <= r.key;
					handle <= r.handle;
					index <= r.index;
					if (!calm_phase && $urandom_range(0, 9) == 0)
						req_idle = $urandom_range(1, 13);
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and stall pattern
	int rsp_idle;
	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			rsp_idle = 0;
		end else begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_answers.size() == 0) begin
					$display("unexpected result at %0t", $time);
					mismatches++;
				end else begin
					a = expected_answers.pop_front();
					if (status !== a.status)
						report_mismatch("status", status, a.status);
					if (found_key !== a.found_key)
						report_mismatch("found_key", found_key, a.found_key);
					if (found_handle !== a.found_handle)
						report_mismatch("found_handle", found_handle, a.found_handle);
					if (entry_count !== a.entry_count)
						report_mismatch("entry_count", entry_count, a.entry_count);
				end
			end
			if (rsp_idle > 0) begin
				rsp_idle--;
				rsp_stall <= 1'b1;
			end else if (!calm_phase && $urandom_range(0, 11) == 0) begin
				rsp_idle = $urandom_range(0, 12);
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// stimulus
	initial begin
		logic [31:0] k;
		int pick;
		mismatches = 0;
		stimulus_done = 0;
		calm_phase = 0;
		model_count = 0;
		req_valid = 1'b0;
		req_type = '0;
		key = '0;
		handle = '0;
		index = '0;
		rsp_stall = 1'b0;
		arst_n = 1'b0;

		// directed: empty table, extremes, rejections, unknown codes
		queue_req(REQ_LOOKUP, 32'd5, 32'd0, 6'd0, 0);
		queue_req(REQ_REMOVE_KEY, 32'd5, 32'd0, 6'd0, 0);
		queue_req(REQ_READ_AT, 32'd0, 32'd0, 6'd0, 0);
		queue_req(REQ_REMOVE_AT, 32'd0, 32'd0, 6'd63, 0);
		queue_req(REQ_INSERT, 32'd0, 32'd7, 6'd0, 0);
		queue_req(REQ_INSERT, 32'd7, 32'd0, 6'd0, 0);
		queue_req(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0, 0);
		queue_req(REQ_INSERT, 32'd1, 32'd1, 6'd0, 0);
		queue_req(REQ_INSERT, 32'h8000_0000, 32'h1234_5678, 6'd0, 0);
		queue_req(REQ_INSERT, 32'd1, 32'd9, 6'd0, 0);
		queue_req(REQ_LOOKUP, 32'h8000_0000, 32'd0, 6'd0, 0);
		queue_req(REQ_LOOKUP, 32'd0, 32'd0, 6'd0, 0);
		queue_req(REQ_REMOVE_KEY, 32'd0, 32'd0, 6'd0, 0);
		queue_req(REQ_LOOKUP, 32'd2, 32'd0, 6'd0, 0);
		queue_req(REQ_READ_AT, 32'd0, 32'd0, 6'd2, 0);
		queue_req(REQ_READ_AT, 32'd0, 32'd0, 6'd3, 0);
		queue_req(3'd6, 32'd1, 32'd1, 6'd0, 0);
		queue_req(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 0);
		queue_req(REQ_REMOVE_AT, 32'd0, 32'd0, 6'd0, 0);
		queue_req(REQ_REMOVE_KEY, 32'hFFFF_FFFF, 32'd0, 6'd0, 1);
		queue_req(REQ_CLEAR, 32'd0, 32'd0, 6'd0, 0);
		// fill to capacity, then one over, duplicate on a full table
		for (int i = 0; i < TBL_DEPTH; i++)
			queue_req(REQ_INSERT, 32'd1000 - 32'(i) * 13, $urandom() | 32'd1, 6'd0, 0);
		queue_req(REQ_INSERT, 32'd3, 32'd3, 6'd0, 0);
		queue_req(REQ_INSERT, 32'd1000, 32'd3, 6'd0, 0);
		queue_req(REQ_READ_AT, 32'd0, 32'd0, 6'd63, 0);
		queue_req(REQ_REMOVE_AT, 32'd0, 32'd0, 6'd63, 0);
		queue_req(REQ_REMOVE_AT, 32'd0, 32'd0, 6'd0, 1);
		queue_req(REQ_CLEAR, 32'd0, 32'd0, 6'd0, 0);

		// random: mostly inserts and hits on live keys
		for (int n = 0; n < 558; n++) begin
			pick = $urandom_range(0, 99);
			if (live_keys.size() > 0)
				k = live_keys[$urandom_range(0, live_keys.size() - 1)];
			else
				k = rand_key();
			if (pick < 38)
				queue_req(REQ_INSERT, ($urandom_range(0, 5) == 0) ? k : rand_key(),
					($urandom_range(0, 30) == 0) ? 32'd0 : $urandom(),
					6'($urandom()), n == 300);
			else if (pick < 55)
				queue_req(REQ_LOOKUP, ($urandom_range(0, 3) == 0) ? rand_key() : k,
					$urandom(), 6'($urandom()), 0);
			else if (pick < 70)
				queue_req(REQ_REMOVE_KEY, ($urandom_range(0, 3) == 0) ? rand_key() : k,
					$urandom(), 6'($urandom()), 0);
			else if (pick < 80)
				queue_req(REQ_REMOVE_AT, $urandom(), $urandom(),
					6'($urandom_range(0, live_keys.size() + 2)), 0);
			else if (pick < 93)
				queue_req(REQ_READ_AT, $urandom(), $urandom(),
					($urandom_range(0, 7) == 0) ? 6'($urandom()) :
					6'($urandom_range(0, live_keys.size() + 1)), 0);
			else if (pick < 95)
				queue_req(REQ_CLEAR, $urandom(), $urandom(), 6'($urandom()), 0);
			else if (pick < 97)
				queue_req(3'($urandom_range(6, 7)), $urandom(), $urandom(),
					6'($urandom()), 0);
			else
				queue_req(REQ_LOOKUP, 32'd0, $urandom(), 6'($urandom()), 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// no idling on the last stretch
		wait (pending_reqs.size() < 80);
		calm_phase = 1;
		wait (pending_reqs.size() == 0);
		@(posedge clk);
		while (req_valid) @(posedge clk);
		wait (expected_answers.size() == 0);
		repeat (300) @(posedge clk);
		if (mismatches == 0 && expected_answers.size() == 0)
			$display("sorted_key_table_core_tb: PASS");
		else
			$display("sorted_key_table_core_tb: FAIL");
		$finish;
	end

	// timeout guard
	initial begin
		#20ms;
		$display("sorted_key_table_core_tb: FAIL");
		$finish;
	end

endmodule
